[rtl/core/afu_pkg.sv]
`default_nettype none

package afu_pkg;

   localparam int DATA_WIDTH      = 24;
   localparam int FRAC_BITS       = 16;
   localparam int TABLE_ADDR_BITS = 8;

   // Q30 internal format, one extra bit to hold the value 1.0
   localparam int Q_BITS   = 30;
   localparam int QW       = Q_BITS + 1;
   localparam int TBL_SIZE = (1 << TABLE_ADDR_BITS) + 1;
   localparam int TBL_IDX_W = TABLE_ADDR_BITS + 1;
   localparam int REM_BITS = Q_BITS - TABLE_ADDR_BITS;

   localparam logic [QW-1:0]     LOG2E_Q30 = 31'd1549082005;
   localparam logic [Q_BITS-1:0] LN2_Q30   = 30'd744261118;

   localparam longint SOFTPLUS_LIMIT = longint'(20) << FRAC_BITS;

   typedef enum logic [1:0] {
      FUNC_SILU     = 2'd0,
      FUNC_SIGMOID  = 2'd1,
      FUNC_SOFTPLUS = 2'd2,
      FUNC_SWIGLU   = 2'd3
   } func_sel_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sample;
      logic signed [DATA_WIDTH-1:0] up_value;
      logic                         last_in;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] activation;
      logic                         last_out;
   } rsp_payload_type;

   typedef logic [QW-1:0] pow2_tbl_type [TBL_SIZE];

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      v    = v_in;
      res  = 64'd0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // 2^(-i/2^B) in Q30, built by repeated square roots of one half
   function automatic pow2_tbl_type build_pow2_tbl();
      pow2_tbl_type tbl;
      logic [63:0]  r;
      logic [63:0]  prod;
      r = 64'd1 << 29;
      for (int i = 0; i < TABLE_ADDR_BITS; i++) begin
         r = isqrt64(r << 30);
      end
      tbl[0] = {1'b1, {Q_BITS{1'b0}}};
      for (int i = 1; i < TBL_SIZE; i++) begin
         prod   = 64'(tbl[i-1]) * r + (64'd1 << 29);
         tbl[i] = QW'(prod >> 30);
      end
      return tbl;
   endfunction

   localparam pow2_tbl_type POW2_TBL = build_pow2_tbl();

endpackage

`default_nettype wire

[rtl/core/activation_function_unit.sv]
`default_nettype none

// Channel     | Ports                            | Moves
// ------------+----------------------------------+------------------------------------
// request     | req_valid, req_stall, req_payload | sample, up_value, last_in
// response    | rsp_valid, rsp_stall, rsp_payload | activation, last_out
// csr         | csr_wr_en, csr_wr_data           | function_select (2 bits)
//
// One transaction enters per cycle unless a valid response is stalled; each result travels
// from the stage that accepts its request to the output over 40 register stages.
// The depth is set by the reciprocal, one quotient bit per stage over 31 stages,
// with the 30 squaring steps of the logarithm running beside it in the same stages.
// Synchronous reset clears the valid bits and selects SiLU.
// A stalled response freezes the whole pipeline and stalls the request side.
module activation_function_unit
   import afu_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire req_payload_type req_payload,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      rsp_payload_type rsp_payload,
   input  wire logic            csr_wr_en,
   input  wire logic [1:0]      csr_wr_data
);

   localparam int DIV_STAGES = QW;
   localparam int DIV_BASE   = 5;
   localparam int SG_IDX     = DIV_BASE + DIV_STAGES;
   localparam int M1_IDX     = SG_IDX + 1;
   localparam int M2_IDX     = SG_IDX + 2;
   localparam int NST        = SG_IDX + 4;
   localparam int T_W        = DATA_WIDTH + QW - FRAC_BITS;
   localparam int K_W        = T_W - Q_BITS;
   localparam int SHIFT_W    = $clog2(QW);
   localparam int PW         = 2 * DATA_WIDTH - FRAC_BITS;
   localparam int RW         = PW + 2;
   localparam int SF_W       = FRAC_BITS + 1;

   localparam logic [QW-1:0] Q_ONE = {1'b1, {Q_BITS{1'b0}}};
   localparam logic signed [RW-1:0] SAT_MAX = {{(RW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [RW-1:0] SAT_MIN = {{(RW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic                         last;
      func_sel_type                 mode;
      logic signed [DATA_WIDTH-1:0] x;
      logic signed [DATA_WIDTH-1:0] up;
      logic [DATA_WIDTH-1:0]        a;
   } carry_type;

   typedef struct packed {
      logic [QW-1:0] p;
      logic [QW-1:0] q;
      logic [QW-1:0] z;
      logic [QW-1:0] lres;
      logic [QW:0]   d;
   } div_type;

   // pipeline control: everything moves together unless the result is held
   logic           adv;
   logic [NST-1:0] vld_ff;
   func_sel_type   func_ff;
   carry_type      c_ff [NST-1];
   carry_type      c_in;

   assign adv       = ~(vld_ff[NST-1] & rsp_stall);
   assign req_stall = ~adv;
   assign rsp_valid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         func_ff <= FUNC_SILU;
      end else if (csr_wr_en) begin
         func_ff <= func_sel_type'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   // stage 0 takes the request and its magnitude
   always_comb begin
      c_in.last = req_payload.last_in;
      c_in.mode = func_ff;
      c_in.x    = req_payload.sample;
      c_in.up   = req_payload.up_value;
      c_in.a    = req_payload.sample[DATA_WIDTH-1] ? (~req_payload.sample + 1'b1)
                                                   : req_payload.sample;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff[0] <= c_in;
         for (int i = 1; i < NST - 1; i++) begin
            c_ff[i] <= c_ff[i-1];
         end
      end
   end

   // stage 1: scale |x| by log2(e)
   logic [DATA_WIDTH+QW-1:0] t_prod;
   logic [T_W-1:0]           t1_ff;

   assign t_prod = (DATA_WIDTH+QW)'(c_ff[0].a) * (DATA_WIDTH+QW)'(LOG2E_Q30);

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff <= t_prod[DATA_WIDTH+QW-1:FRAC_BITS];
      end
   end

   // stage 2: table lookup of 2^-f, both neighbors
   logic [TABLE_ADDR_BITS-1:0] idx2;
   logic [TBL_IDX_W-1:0]       idx2_hi;
   logic [TBL_IDX_W-1:0]       idx2_lo;
   logic [QW-1:0]              hi2;
   logic [QW-1:0]              lo2;
   logic [K_W-1:0]             k2_ff;
   logic [QW-1:0]              hi2_ff;
   logic [QW-1:0]              diff2_ff;
   logic [REM_BITS-1:0]        rem2_ff;

   assign idx2    = t1_ff[Q_BITS-1:REM_BITS];
   assign idx2_hi = {1'b0, idx2};
   assign idx2_lo = {1'b0, idx2} + {{TABLE_ADDR_BITS{1'b0}}, 1'b1};
   assign hi2     = POW2_TBL[idx2_hi];
   assign lo2     = POW2_TBL[idx2_lo];

   always_ff @(posedge clock) begin
      if (adv) begin
         k2_ff    <= t1_ff[T_W-1:Q_BITS];
         hi2_ff   <= hi2;
         diff2_ff <= hi2 - lo2;
         rem2_ff  <= t1_ff[REM_BITS-1:0];
      end
   end

   // stage 3: interpolation product
   logic [QW+REM_BITS-1:0] i_prod;
   logic [K_W-1:0]         k3_ff;
   logic [QW-1:0]          hi3_ff;
   logic [QW-1:0]          sh3_ff;

   assign i_prod = (QW+REM_BITS)'(diff2_ff) * (QW+REM_BITS)'(rem2_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         k3_ff  <= k2_ff;
         hi3_ff <= hi2_ff;
         sh3_ff <= i_prod[QW+REM_BITS-1:REM_BITS];
      end
   end

   // stage 4: e^-|x| = interpolated value shifted by the integer part
   logic [QW-1:0] v4;
   logic [QW-1:0] e4_ff;

   assign v4 = hi3_ff - sh3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         e4_ff <= (k3_ff >= K_W'(QW)) ? '0 : (v4 >> k3_ff[SHIFT_W-1:0]);
      end
   end

   // reciprocal 2^60 / (1 + e), one quotient bit per stage; log2(1 + e) beside it
   div_type div_ff [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      div_type       nxt;
      logic [QW:0]   p2;

      if (j == 0) begin : g_head
         logic [QW:0] d0;
         assign d0 = {1'b0, e4_ff} + {1'b0, Q_ONE};
         always_comb begin
            nxt.d = d0;
            if (d0[QW]) begin
               nxt.z    = d0[QW:1];
               nxt.lres = Q_ONE;
            end else begin
               nxt.z    = d0[QW-1:0];
               nxt.lres = '0;
            end
            p2    = {Q_ONE, 1'b0} >> 1;
            nxt.q = '0;
            if (p2 >= d0) begin
               nxt.p              = QW'(p2 - d0);
               nxt.q[QW-1-j]      = 1'b1;
            end else begin
               nxt.p = p2[QW-1:0];
            end
         end
      end else begin : g_tail
         logic [2*QW-1:0] zz;
         assign zz = (2*QW)'(div_ff[j-1].z) * (2*QW)'(div_ff[j-1].z);
         always_comb begin
            nxt.d    = div_ff[j-1].d;
            nxt.lres = div_ff[j-1].lres;
            if (zz[Q_BITS+QW]) begin
               nxt.z                  = zz[Q_BITS+QW:Q_BITS+1];
               nxt.lres[Q_BITS-j]     = 1'b1;
            end else begin
               nxt.z = zz[Q_BITS+QW-1:Q_BITS];
            end
            p2    = {div_ff[j-1].p, 1'b0};
            nxt.q = div_ff[j-1].q;
            if (p2 >= div_ff[j-1].d) begin
               nxt.p         = QW'(p2 - div_ff[j-1].d);
               nxt.q[QW-1-j] = 1'b1;
            end else begin
               nxt.p = p2[QW-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[j] <= nxt;
         end
      end
   end

   // sigmoid from the reciprocal
   logic [QW-1:0] q_fin;
   logic [QW-1:0] sig_ff;
   logic [QW-1:0] lres_ff;

   assign q_fin = div_ff[DIV_STAGES-1].q;

   always_ff @(posedge clock) begin
      if (adv) begin
         sig_ff  <= c_ff[SG_IDX-1].x[DATA_WIDTH-1] ? (Q_ONE - q_fin) : q_fin;
         lres_ff <= div_ff[DIV_STAGES-1].lres;
      end
   end

   // m1: |x| * sigmoid rounded to the 16 fraction bits of the sample, log2 -> ln rounded to Q30
   logic [DATA_WIDTH+QW-1:0] m_prod;
   logic [QW+Q_BITS-1:0]     l_prod;
   logic [DATA_WIDTH-1:0]    m1_ff;
   logic [QW-1:0]            ln1_ff;
   logic [QW-1:0]            sig1_ff;

   assign m_prod = (DATA_WIDTH+QW)'(c_ff[M1_IDX-1].a) * (DATA_WIDTH+QW)'(sig_ff)
                 + ((DATA_WIDTH+QW)'(1) << (Q_BITS - 1));
   assign l_prod = (QW+Q_BITS)'(lres_ff) * (QW+Q_BITS)'(LN2_Q30)
                 + ((QW+Q_BITS)'(1) << (Q_BITS - 1));

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff   <= m_prod[Q_BITS+DATA_WIDTH-1:Q_BITS];
         ln1_ff  <= l_prod[QW+Q_BITS-1:Q_BITS];
         sig1_ff <= sig_ff;
      end
   end

   // m2: gate product for SwiGLU, Q30 -> output format for the rest
   logic [DATA_WIDTH-1:0]   up_mag;
   logic [2*DATA_WIDTH-1:0] p_prod;
   logic [QW-1:0]           sig_rnd;
   logic [QW-1:0]           ln_rnd;
   logic [PW-1:0]           p2_ff;
   logic [SF_W-1:0]         sigf2_ff;
   logic [SF_W-1:0]         lnf2_ff;
   logic [DATA_WIDTH-1:0]   m2_ff;
   logic                    big2_ff;

   assign up_mag  = c_ff[M2_IDX-1].up[DATA_WIDTH-1] ? (~c_ff[M2_IDX-1].up + 1'b1)
                                                     : c_ff[M2_IDX-1].up;
   assign p_prod  = (2*DATA_WIDTH)'(m1_ff) * (2*DATA_WIDTH)'(up_mag)
                  + ((2*DATA_WIDTH)'(1) << (FRAC_BITS - 1));
   assign sig_rnd = sig1_ff + (QW'(1) << (Q_BITS - 1 - FRAC_BITS));
   assign ln_rnd  = ln1_ff + (QW'(1) << (Q_BITS - 1 - FRAC_BITS));

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_ff    <= p_prod[2*DATA_WIDTH-1:FRAC_BITS];
         sigf2_ff <= sig_rnd[QW-1:Q_BITS-FRAC_BITS];
         lnf2_ff  <= ln_rnd[QW-1:Q_BITS-FRAC_BITS];
         m2_ff    <= m1_ff;
         big2_ff  <= longint'(c_ff[M2_IDX-1].x) > SOFTPLUS_LIMIT;
      end
   end

   // output stage: select by function, apply sign, saturate
   carry_type              cf;
   logic signed [RW-1:0]   x_w;
   logic signed [RW-1:0]   m_w;
   logic signed [RW-1:0]   p_w;
   logic signed [RW-1:0]   res;
   logic signed [RW-1:0]   sat;

   assign cf  = c_ff[NST-2];
   assign x_w = RW'(cf.x);
   assign m_w = $signed(RW'(m2_ff));
   assign p_w = $signed(RW'(p2_ff));

   always_comb begin
      case (cf.mode)
         FUNC_SILU:    res = cf.x[DATA_WIDTH-1] ? -m_w : m_w;
         FUNC_SIGMOID: res = $signed(RW'(sigf2_ff));
         FUNC_SOFTPLUS: begin
            if (big2_ff) begin
               res = x_w;
            end else begin
               res = (cf.x[DATA_WIDTH-1] ? '0 : x_w) + $signed(RW'(lnf2_ff));
            end
         end
         FUNC_SWIGLU:  res = (cf.x[DATA_WIDTH-1] ^ cf.up[DATA_WIDTH-1]) ? -p_w : p_w;
         default:      res = '0;
      endcase
      if (res > SAT_MAX) begin
         sat = SAT_MAX;
      end else if (res < SAT_MIN) begin
         sat = SAT_MIN;
      end else begin
         sat = res;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_payload.activation <= sat[DATA_WIDTH-1:0];
         rsp_payload.last_out   <= cf.last;
      end
   end

endmodule

`default_nettype wire
